// ===== design/cjb_pkg.sv =====
`default_nettype none

package cjb_pkg;

  // Default sizes handed to the top level.
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_MAX_SEEDS   = 16;
  localparam int DEF_ET_BITS     = 13;
  localparam int DEF_ETA_W       = 11;
  localparam int DEF_PHI_W       = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam int R2_W       = 40;
  localparam int WEIGHT_W   = 16;
  localparam int MAXC_W     = 9;
  localparam int SEED_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_R2_CUT         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_WEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_WEIGHT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CONSIDERED = 2'd3;

  localparam logic [R2_W-1:0]     RST_R2_CUT         = 40'd1000000;
  localparam logic [WEIGHT_W-1:0] RST_ETA_WEIGHT     = 16'd1;
  localparam logic [WEIGHT_W-1:0] RST_PHI_WEIGHT     = 16'd1;
  localparam logic [MAXC_W-1:0]   RST_MAX_CONSIDERED = 9'd64;

  // Request kinds carried in the low tuser bit.
  localparam logic KIND_OBJECT = 1'b0;
  localparam logic KIND_SEED   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Tag that travels beside a table entry through the distance pipeline.
  typedef struct packed {
    logic valid;
    logic live;
  } ctl_t;

endpackage

`default_nettype wire

// ===== design/seeded_cone_jet_builder.sv =====
// Seeded cone jet builder.
// Requests arrive on the s_axis channel. An object request (tuser kind 0)
// stores Et, eta and phi in the event table; with new_event set
// it first empties the table, the seed counter and the drop flag. A seed
// request (tuser kind 1) walks the table in load order and merges every live
// object within the weighted cone into the seed's Et, marking it consumed.
// Each seed of an event, up to MAX_SEEDS, yields one result request on the
// m_axis channel; later seeds are absorbed without a result.
// A seed reads the table one entry per cycle, up to the table fill or until
// max_considered live entries outside the cone have been examined; the
// three-stage read and distance pipeline then drains, and the next request
// is taken the cycle after the result is loaded. An object request leaves
// the block idle, so the next request can be taken right after it.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is already accepted, and only a finished seed
// waits for the register to free up.
// Reset clears the configuration to its defaults and empties the event; the
// table memories need no clearing pass, since only entries below the fill
// count are ever read.
`default_nettype none

module seeded_cone_jet_builder #(
  parameter int TABLE_DEPTH = cjb_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_SEEDS   = cjb_pkg::DEF_MAX_SEEDS,
  parameter int ET_BITS     = cjb_pkg::DEF_ET_BITS,
  parameter int ETA_W       = cjb_pkg::DEF_ETA_W,
  parameter int PHI_W       = cjb_pkg::DEF_PHI_W
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // Fields from bit 0 up: et_code, eta_code, phi_code, zero fill.
  input  wire logic [((ET_BITS+ETA_W+PHI_W+7)/8)*8-1:0] s_axis_tdata,
  // Fields from bit 0 up: kind, new_event.
  input  wire logic [1:0]                          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // Fields from bit 0 up: seed_index, jet_et, jet_eta, jet_phi, zero fill.
  output logic [((cjb_pkg::SEED_IDX_W+ET_BITS+ETA_W+PHI_W+7)/8)*8-1:0] m_axis_tdata,
  // Fields from bit 0 up: et_saturated, objects_dropped.
  output logic      [1:0]                          m_axis_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [cjb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cjb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int FLD_W  = ET_BITS + ETA_W + PHI_W;
  localparam int OUT_W  = ((cjb_pkg::SEED_IDX_W + FLD_W + 7) / 8) * 8;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SEED_W = $clog2(MAX_SEEDS + 1);
  localparam int MAXC_W = cjb_pkg::MAXC_W;

  // Configuration registers.
  logic [cjb_pkg::R2_W-1:0]     r2_cut;
  logic [cjb_pkg::WEIGHT_W-1:0] eta_weight;
  logic [cjb_pkg::WEIGHT_W-1:0] phi_weight;
  logic [MAXC_W-1:0]            max_considered;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_cut         <= cjb_pkg::RST_R2_CUT;
      eta_weight     <= cjb_pkg::RST_ETA_WEIGHT;
      phi_weight     <= cjb_pkg::RST_PHI_WEIGHT;
      max_considered <= cjb_pkg::RST_MAX_CONSIDERED;
    end else if (cfg_we) begin
      case (cfg_index)
        cjb_pkg::REG_R2_CUT:         r2_cut         <= cfg_data[cjb_pkg::R2_W-1:0];
        cjb_pkg::REG_ETA_WEIGHT:     eta_weight     <= cfg_data[cjb_pkg::WEIGHT_W-1:0];
        cjb_pkg::REG_PHI_WEIGHT:     phi_weight     <= cfg_data[cjb_pkg::WEIGHT_W-1:0];
        cjb_pkg::REG_MAX_CONSIDERED: max_considered <= cfg_data[MAXC_W-1:0];
        default: ;
      endcase
    end
  end

  // Input request fields.
  logic                in_kind;
  logic                in_new;
  logic [ET_BITS-1:0]  in_et;
  logic [ETA_W-1:0]    in_eta;
  logic [PHI_W-1:0]    in_phi;

  assign in_kind = s_axis_tuser[0];
  assign in_new  = s_axis_tuser[1];
  assign in_et   = s_axis_tdata[ET_BITS-1:0];
  assign in_eta  = s_axis_tdata[ET_BITS+ETA_W-1:ET_BITS];
  assign in_phi  = s_axis_tdata[FLD_W-1:ET_BITS+ETA_W];

  // Control and event state.
  cjb_pkg::state_t     state;
  logic [CNT_W-1:0]    object_count;
  logic [SEED_W-1:0]   seed_counter;
  logic                drop_flag;
  logic [CNT_W-1:0]    issue_idx;
  logic [MAXC_W-1:0]   seen;
  logic                rd_valid;
  logic [ADDR_W-1:0]   rd_addr;

  // Seed being walked and its running sum.
  logic [ETA_W-1:0]    seed_eta;
  logic [PHI_W-1:0]    seed_phi;
  logic [ET_BITS-1:0]  jet_sum;
  logic                jet_sat;

  // Output register.
  logic [cjb_pkg::SEED_IDX_W-1:0] out_index;
  logic [ET_BITS-1:0]             out_et;
  logic [ETA_W-1:0]               out_eta;
  logic [PHI_W-1:0]               out_phi;
  logic                           out_sat;
  logic                           out_drop;

  logic              accept;
  logic              load_we;
  logic [CNT_W-1:0]  load_cnt;
  logic              load_ok;
  logic              issue;
  logic              walk_done;
  logic              out_free;

  // Table memories: the object payload and a consumed mark per entry.
  logic [FLD_W-1:0]  obj_rdata;
  logic              used_rdata;
  logic              used_we;
  logic [ADDR_W-1:0] used_waddr;

  // Distance pipeline outputs.
  cjb_pkg::ctl_t     d_ctl;
  logic [ET_BITS-1:0] d_et;
  logic [ADDR_W-1:0] d_addr;
  logic              d_close;
  logic              d_busy;
  cjb_pkg::ctl_t     rd_ctl;

  logic              take;
  logic              merge_we;
  logic [ET_BITS:0]  sum_wide;

  assign s_axis_tready = (state == cjb_pkg::S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;

  // An object with new_event set starts a fresh table at entry zero.
  assign load_cnt = in_new ? CNT_W'(0) : object_count;
  assign load_ok  = load_cnt < CNT_W'(TABLE_DEPTH);
  assign load_we  = accept & (in_kind == cjb_pkg::KIND_OBJECT) & load_ok;

  // Reads run ahead of the decision; entries read after the examine limit
  // is reached are ignored when they come out of the pipeline.
  assign issue = (state == cjb_pkg::S_WALK) & (issue_idx < object_count) &
                 (seen < max_considered);
  assign walk_done = (state == cjb_pkg::S_WALK) & ~issue & ~rd_valid & ~d_busy;
  assign out_free  = ~m_axis_tvalid | m_axis_tready;

  assign take     = d_ctl.valid & d_ctl.live & (seen < max_considered);
  assign merge_we = take & d_close;
  assign sum_wide = {1'b0, jet_sum} + {1'b0, d_et};

  // Loads and merge write-backs never share a cycle: loads happen only
  // while idle, write-backs only during a walk.
  assign used_we    = load_we | merge_we;
  assign used_waddr = load_we ? load_cnt[ADDR_W-1:0] : d_addr;

  cjb_ram #(
    .WIDTH (FLD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_obj_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_cnt[ADDR_W-1:0]),
    .wdata ({in_phi, in_eta, in_et}),
    .re    (issue),
    .raddr (issue_idx[ADDR_W-1:0]),
    .rdata (obj_rdata)
  );

  cjb_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (merge_we),
    .re    (issue),
    .raddr (issue_idx[ADDR_W-1:0]),
    .rdata (used_rdata)
  );

  assign rd_ctl.valid = rd_valid;
  assign rd_ctl.live  = ~used_rdata;

  cjb_dist #(
    .ETA_W   (ETA_W),
    .PHI_W   (PHI_W),
    .ET_BITS (ET_BITS),
    .ADDR_W  (ADDR_W)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (rd_ctl),
    .in_et      (obj_rdata[ET_BITS-1:0]),
    .in_eta     (obj_rdata[ET_BITS+ETA_W-1:ET_BITS]),
    .in_phi     (obj_rdata[FLD_W-1:ET_BITS+ETA_W]),
    .in_addr    (rd_addr),
    .seed_eta   (seed_eta),
    .seed_phi   (seed_phi),
    .eta_weight (eta_weight),
    .phi_weight (phi_weight),
    .r2_cut     (r2_cut),
    .out_ctl    (d_ctl),
    .out_et     (d_et),
    .out_addr   (d_addr),
    .out_close  (d_close),
    .busy       (d_busy)
  );

  // Sequencer and event bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cjb_pkg::S_IDLE;
      object_count  <= '0;
      seed_counter  <= '0;
      drop_flag     <= 1'b0;
      issue_idx     <= '0;
      seen          <= '0;
      rd_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
      if (take & ~d_close) begin
        seen <= seen + MAXC_W'(1);
      end
      if ((state == cjb_pkg::S_DONE) & out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid & m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        cjb_pkg::S_IDLE: begin
          if (accept) begin
            if (in_kind == cjb_pkg::KIND_OBJECT) begin
              if (in_new) begin
                seed_counter <= '0;
              end
              if (load_ok) begin
                object_count <= load_cnt + CNT_W'(1);
                drop_flag    <= in_new ? 1'b0 : drop_flag;
              end else begin
                object_count <= load_cnt;
                drop_flag    <= 1'b1;
              end
            end else if (seed_counter < SEED_W'(MAX_SEEDS)) begin
              issue_idx <= '0;
              seen      <= '0;
              state     <= cjb_pkg::S_WALK;
            end
          end
        end
        cjb_pkg::S_WALK: begin
          if (walk_done) begin
            state <= cjb_pkg::S_DONE;
          end
        end
        cjb_pkg::S_DONE: begin
          if (out_free) begin
            seed_counter  <= seed_counter + SEED_W'(1);
            state         <= cjb_pkg::S_IDLE;
          end
        end
        default: begin
          state <= cjb_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Seed payload, running sum and read address tag.
  always_ff @(posedge clk) begin
    rd_addr <= issue_idx[ADDR_W-1:0];
    if (accept & (in_kind == cjb_pkg::KIND_SEED)) begin
      seed_eta <= in_eta;
      seed_phi <= in_phi;
      jet_sum  <= in_et;
      jet_sat  <= 1'b0;
    end else if (merge_we) begin
      // The sum only grows, so clipping on the way gives the same flag as
      // clipping at the end.
      if (sum_wide[ET_BITS]) begin
        jet_sum <= '1;
        jet_sat <= 1'b1;
      end else begin
        jet_sum <= sum_wide[ET_BITS-1:0];
      end
    end
    if ((state == cjb_pkg::S_DONE) & out_free) begin
      out_index <= cjb_pkg::SEED_IDX_W'(seed_counter);
      out_et    <= jet_sum;
      out_eta   <= seed_eta;
      out_phi   <= seed_phi;
      out_sat   <= jet_sat;
      out_drop  <= drop_flag;
    end
  end

  assign m_axis_tdata = OUT_W'({out_phi, out_eta, out_et, out_index});
  assign m_axis_tuser = {out_drop, out_sat};

endmodule

`default_nettype wire

// ===== design/cjb_ram.sv =====
`default_nettype none

module cjb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/cjb_dist.sv =====
`default_nettype none

// Two-stage distance pipeline. The first stage forms the squared eta and
// phi differences, the second weights them. The merge decision is the sum
// of the weighted terms compared against the cut.
module cjb_dist #(
  parameter int ETA_W   = cjb_pkg::DEF_ETA_W,
  parameter int PHI_W   = cjb_pkg::DEF_PHI_W,
  parameter int ET_BITS = cjb_pkg::DEF_ET_BITS,
  parameter int ADDR_W  = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire cjb_pkg::ctl_t                   in_ctl,
  input  wire logic [ET_BITS-1:0]              in_et,
  input  wire logic [ETA_W-1:0]                in_eta,
  input  wire logic [PHI_W-1:0]                in_phi,
  input  wire logic [ADDR_W-1:0]               in_addr,
  input  wire logic [ETA_W-1:0]                seed_eta,
  input  wire logic [PHI_W-1:0]                seed_phi,
  input  wire logic [cjb_pkg::WEIGHT_W-1:0]    eta_weight,
  input  wire logic [cjb_pkg::WEIGHT_W-1:0]    phi_weight,
  input  wire logic [cjb_pkg::R2_W-1:0]        r2_cut,
  output cjb_pkg::ctl_t                        out_ctl,
  output logic      [ET_BITS-1:0]              out_et,
  output logic      [ADDR_W-1:0]               out_addr,
  output logic                                 out_close,
  output logic                                 busy
);

  localparam int ESQ_W = 2 * ETA_W;
  localparam int PSQ_W = 2 * PHI_W;
  localparam int ETW_W = cjb_pkg::WEIGHT_W + ESQ_W;
  localparam int PTW_W = cjb_pkg::WEIGHT_W + PSQ_W;
  localparam int SUM_W = ((ETW_W > PTW_W) ? ETW_W : PTW_W) + 1;
  localparam int CMP_W = (SUM_W > cjb_pkg::R2_W) ? SUM_W : cjb_pkg::R2_W;
  localparam logic [PHI_W-1:0] PHI_HALF = {1'b1, {(PHI_W-1){1'b0}}};

  logic [ETA_W-1:0] deta;
  logic [PHI_W-1:0] phi_diff;
  logic [PHI_W-1:0] dphi;

  cjb_pkg::ctl_t       a_ctl;
  logic [ET_BITS-1:0]  a_et;
  logic [ADDR_W-1:0]   a_addr;
  logic [ESQ_W-1:0]    a_esq;
  logic [PSQ_W-1:0]    a_psq;

  logic [ETW_W-1:0]    b_eterm;
  logic [PTW_W-1:0]    b_pterm;
  logic [SUM_W-1:0]    b_sum;

  always_comb begin
    deta     = (seed_eta >= in_eta) ? (seed_eta - in_eta) : (in_eta - seed_eta);
    phi_diff = seed_phi - in_phi;
    // Take the shorter way round the circle.
    dphi     = (phi_diff > PHI_HALF) ? (PHI_W'(0) - phi_diff) : phi_diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      out_ctl <= '0;
    end else begin
      a_ctl   <= in_ctl;
      out_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    a_et     <= in_et;
    a_addr   <= in_addr;
    a_esq    <= ESQ_W'(deta) * ESQ_W'(deta);
    a_psq    <= PSQ_W'(dphi) * PSQ_W'(dphi);
    out_et   <= a_et;
    out_addr <= a_addr;
    b_eterm  <= ETW_W'(eta_weight) * ETW_W'(a_esq);
    b_pterm  <= PTW_W'(phi_weight) * PTW_W'(a_psq);
  end

  always_comb begin
    b_sum     = SUM_W'(b_eterm) + SUM_W'(b_pterm);
    out_close = CMP_W'(b_sum) <= CMP_W'(r2_cut);
    busy      = a_ctl.valid | out_ctl.valid;
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cjb_pkg::*;

  // Sizes of the block as instantiated (package defaults).
  localparam int ETB   = DEF_ET_BITS;
  localparam int ETAB  = DEF_ETA_W;
  localparam int PHIB  = DEF_PHI_W;
  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int SEEDS = DEF_MAX_SEEDS;

  localparam int IN_W  = ((ETB + ETAB + PHIB + 7) / 8) * 8;
  localparam int OUT_W = ((SEED_IDX_W + ETB + ETAB + PHIB + 7) / 8) * 8;

  // Bit offsets of the result fields inside m_axis_tdata.
  localparam int ET_LO  = SEED_IDX_W;
  localparam int ETA_LO = ET_LO + ETB;
  localparam int PHI_LO = ETA_LO + ETAB;

  localparam int ET_MAX   = (1 << ETB) - 1;
  localparam int ETA_MAX  = (1 << ETAB) - 1;
  localparam int PHI_HALF = 1 << (PHIB - 1);
  localparam int PHI_FULL = 1 << PHIB;

  // A seed reads at most the whole table plus the pipeline drain; this pause
  // covers a seed that is absorbed without a result, or still walking, before
  // any register is touched.
  localparam int SETTLE_CYCLES = DEPTH + 44;

  // The slowest correct run is roughly 750 requests, each a full table walk
  // plus the longest sender gap and receiver stall, plus the settle pauses:
  // well under the cycle limit.
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic            kind;
    logic            new_event;
    logic [ETB-1:0]  et;
    logic [ETAB-1:0] eta;
    logic [PHIB-1:0] phi;
  } jet_req_t;

  typedef struct packed {
    logic [SEED_IDX_W-1:0] seed_index;
    logic [ETB-1:0]        et;
    logic [ETAB-1:0]       eta;
    logic [PHIB-1:0]       phi;
    logic                  sat;
    logic                  dropped;
  } jet_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // Fields from bit 0 up: et_code, eta_code, phi_code.
  logic [IN_W-1:0]  s_axis_tdata = '0;
  // Fields from bit 0 up: kind, new_event.
  logic [1:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // Fields from bit 0 up: seed_index, jet_et, jet_eta, jet_phi.
  logic [OUT_W-1:0] m_axis_tdata;
  // Fields from bit 0 up: et_saturated, objects_dropped.
  logic [1:0]       m_axis_tuser;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  seeded_cone_jet_builder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Requests still to be sent, and jets the block owes us, oldest first.
  jet_req_t req_q[$];
  jet_t     jet_q[$];

  int errors = 0;
  int cycles = 0;

  // Shadow of the configuration registers, updated as they are written.
  logic [R2_W-1:0]     cut_r2     = RST_R2_CUT;
  logic [WEIGHT_W-1:0] w_eta      = RST_ETA_WEIGHT;
  logic [WEIGHT_W-1:0] w_phi      = RST_PHI_WEIGHT;
  logic [MAXC_W-1:0]   walk_limit = RST_MAX_CONSIDERED;

  // Shadow of the event table and the per-event counters.
  logic [ETB-1:0]  tab_et  [DEPTH];
  logic [ETAB-1:0] tab_eta [DEPTH];
  logic [PHIB-1:0] tab_phi [DEPTH];
  logic [DEPTH-1:0] tab_live = '0;
  int  tab_fill   = 0;
  int  seeds_seen = 0;
  logic lost_obj  = 1'b0;

  // Weighted squared distance from a seed to a stored object. The phi
  // difference is taken the short way round the circle; exactly half a turn
  // stays at half a turn.
  function automatic logic [63:0] cone_dist(input logic [ETAB-1:0] ea,
                                            input logic [PHIB-1:0] pa,
                                            input logic [ETAB-1:0] eb,
                                            input logic [PHIB-1:0] pb);
    logic [63:0]     de;
    logic [63:0]     dp;
    logic [PHIB-1:0] wrap;
    de   = (ea >= eb) ? 64'(ea) - 64'(eb) : 64'(eb) - 64'(ea);
    wrap = pa - pb;
    dp   = 64'(wrap);
    if (dp > PHI_HALF)
      dp = PHI_FULL - dp;
    return 64'(w_eta) * de * de + 64'(w_phi) * dp * dp;
  endfunction

  // Applies one accepted request to the shadow table. A seed within the
  // event's seed budget walks the live entries in load order and yields the
  // jet that the block must return.
  task automatic build_jet(input jet_req_t r);
    int   sum;
    int   passed;
    int   i;
    jet_t j;
    if (r.kind == KIND_OBJECT) begin
      if (r.new_event) begin
        tab_live   = '0;
        tab_fill   = 0;
        seeds_seen = 0;
        lost_obj   = 1'b0;
      end
      if (tab_fill < DEPTH) begin
        tab_et[tab_fill]   = r.et;
        tab_eta[tab_fill]  = r.eta;
        tab_phi[tab_fill]  = r.phi;
        tab_live[tab_fill] = 1'b1;
        tab_fill++;
      end else begin
        lost_obj = 1'b1;
      end
    end else if (seeds_seen < SEEDS) begin
      sum    = int'(r.et);
      passed = 0;
      for (i = 0; i < tab_fill && passed < walk_limit; i++) begin
        if (tab_live[i]) begin
          if (cone_dist(r.eta, r.phi, tab_eta[i], tab_phi[i]) <= cut_r2) begin
            sum += int'(tab_et[i]);
            tab_live[i] = 1'b0;
          end else begin
            passed++;
          end
        end
      end
      j.seed_index = SEED_IDX_W'(seeds_seen);
      j.sat        = (sum > ET_MAX);
      j.et         = j.sat ? ETB'(ET_MAX) : ETB'(sum);
      j.eta        = r.eta;
      j.phi        = r.phi;
      j.dropped    = lost_obj;
      jet_q.insert(jet_q.size(), j);
      seeds_seen++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender. Requests leave req_q in bursts of random length separated by
  // random gaps; about a quarter of the bursts follow on with no gap at
  // all. A request is predicted at the edge where it is accepted, so the
  // shadow state always moves in the same order as the block's.
  // ---------------------------------------------------------------------
  jet_req_t cur_req;
  int  burst_left = 1;
  int  gap_left   = 0;
  logic sent;
  logic show;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      sent = s_axis_tvalid && s_axis_tready;
      if (sent)
        build_jet(cur_req);
      if (!s_axis_tvalid || sent) begin
        show = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          show    = 1'b1;
          s_axis_tdata <= {cur_req.phi, cur_req.eta, cur_req.et};
          s_axis_tuser <= {cur_req.new_event, cur_req.kind};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        s_axis_tvalid <= show;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver. It switches at random intervals between three habits:
  // always ready, ready on a coin toss, and runs of stalls broken by
  // short ready windows. Every accepted jet is checked against
  // the oldest one predicted.
  // ---------------------------------------------------------------------
  int   rx_mode      = 0;
  int   rx_mode_left = 0;
  int   rx_run       = 0;
  logic rx_low       = 1'b0;
  logic rx_ready;
  jet_t got;
  jet_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.seed_index = m_axis_tdata[0 +: SEED_IDX_W];
        got.et         = m_axis_tdata[ET_LO +: ETB];
        got.eta        = m_axis_tdata[ETA_LO +: ETAB];
        got.phi        = m_axis_tdata[PHI_LO +: PHIB];
        got.sat        = m_axis_tuser[0];
        got.dropped    = m_axis_tuser[1];
        if (jet_q.size() == 0) begin
          if (errors < 10)
            $display("jet with none outstanding: idx %0d et %0d eta %0d phi %0d sat %0b drop %0b",
                     got.seed_index, got.et, got.eta, got.phi, got.sat, got.dropped);
          errors++;
        end else begin
          want = jet_q.pop_front();
          if (got.seed_index !== want.seed_index || got.et !== want.et ||
              got.eta !== want.eta || got.phi !== want.phi ||
              got.sat !== want.sat || got.dropped !== want.dropped) begin
            if (errors < 10) begin
              $display("jet mismatch, expected idx %0d et %0d eta %0d phi %0d sat %0b drop %0b",
                       want.seed_index, want.et, want.eta, want.phi, want.sat, want.dropped);
              $display("               actual idx %0d et %0d eta %0d phi %0d sat %0b drop %0b",
                       got.seed_index, got.et, got.eta, got.phi, got.sat, got.dropped);
            end
            errors++;
          end
        end
      end

      if (rx_mode_left <= 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(50, 400);
      end
      rx_mode_left--;
      case (rx_mode)
        0: rx_ready = 1'b1;
        1: rx_ready = 1'($urandom_range(0, 1));
        default: begin
          if (rx_run <= 0) begin
            rx_low = !rx_low;
            rx_run = rx_low ? $urandom_range(1, 16) : $urandom_range(1, 4);
          end
          rx_run--;
          rx_ready = !rx_low;
        end
      endcase
      m_axis_tready <= rx_ready;
    end
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_req(input logic kind, input logic fresh, input int et,
                          input int eta, input int phi);
    jet_req_t r;
    r.kind      = kind;
    r.new_event = fresh;
    r.et        = ETB'(et);
    r.eta       = ETAB'(eta);
    r.phi       = PHIB'(phi);
    req_q.insert(req_q.size(), r);
  endtask

  // Waits until every request has gone out and every jet has come back,
  // then waits long enough for a full table walk and drain.
  task automatic drain();
    while (req_q.size() != 0 || s_axis_tvalid || jet_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges. The shadow copy keeps
  // only the bits that fit each register, as the block does.
  task automatic set_cuts(input logic [CFG_DATA_W-1:0] r2,
                          input logic [CFG_DATA_W-1:0] we,
                          input logic [CFG_DATA_W-1:0] wp,
                          input logic [CFG_DATA_W-1:0] mc);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_R2_CUT;
    cfg_data  <= r2;
    cut_r2     = r2[R2_W-1:0];
    @(posedge clk);
    cfg_index <= REG_ETA_WEIGHT;
    cfg_data  <= we;
    w_eta      = we[WEIGHT_W-1:0];
    @(posedge clk);
    cfg_index <= REG_PHI_WEIGHT;
    cfg_data  <= wp;
    w_phi      = wp[WEIGHT_W-1:0];
    @(posedge clk);
    cfg_index <= REG_MAX_CONSIDERED;
    cfg_data  <= mc;
    walk_limit = mc[MAXC_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Positions of the objects of the event being built, so that some seeds
  // can land exactly on an object.
  int ev_eta[$];
  int ev_phi[$];
  int gen_seeds = 0;

  // Builds whole events until about `budget` requests that the block acts
  // on have been queued. Objects cluster around a random center, wide or
  // narrow; seeds sit on an object, near the center or anywhere. Some events
  // skip new_event and pile onto the previous table, and some get a few
  // late objects and seeds after their seeds. With `big` set the first
  // event overfills the table.
  task automatic gen_events(input int budget, input bit big);
    int counted;
    int n_obj;
    int n_seed;
    int k;
    int sp;
    int ce;
    int cp;
    int e;
    int p;
    int pick;
    int n_tail;
    bit fresh;
    counted = 0;
    while (counted < budget) begin
      n_obj = big ? $urandom_range(258, 272) : $urandom_range(1, 24);
      big   = 1'b0;
      ce    = $urandom_range(0, ETA_MAX);
      cp    = $urandom_range(0, PHI_FULL - 1);
      sp    = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(1, 40);
      fresh = ($urandom_range(0, 9) != 0);
      if (fresh) begin
        gen_seeds = 0;
        ev_eta.delete();
        ev_phi.delete();
      end
      n_tail = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
      for (k = 0; k < n_obj + n_tail; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          e = $urandom_range(0, ETA_MAX);
          p = $urandom_range(0, PHI_FULL - 1);
        end else begin
          e = ce + $urandom_range(0, 2 * sp) - sp;
          e = (e < 0) ? 0 : (e > ETA_MAX) ? ETA_MAX : e;
          p = (cp + $urandom_range(0, 2 * sp) - sp) & (PHI_FULL - 1);
        end
        ev_eta.insert(ev_eta.size(), e);
        ev_phi.insert(ev_phi.size(), p);
        push_req(KIND_OBJECT, (k == 0) && fresh,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, ET_MAX)
                                             : $urandom_range(0, 700), e, p);
        counted++;
        // Late objects land after the seeds of the event.
        if (k == n_obj - 1 || (k >= n_obj && k < n_obj + n_tail - 1)) begin
          n_seed = (k == n_obj - 1) ? $urandom_range(1, 20) : $urandom_range(0, 1);
          repeat (n_seed) begin
            pick = $urandom_range(0, 4);
            if (pick <= 1) begin
              pick = $urandom_range(0, ev_eta.size() - 1);
              e    = ev_eta[pick];
              p    = ev_phi[pick];
            end else if (pick <= 3) begin
              e = ce + $urandom_range(0, 2 * sp) - sp;
              e = (e < 0) ? 0 : (e > ETA_MAX) ? ETA_MAX : e;
              p = (cp + $urandom_range(0, 2 * sp) - sp) & (PHI_FULL - 1);
            end else begin
              e = $urandom_range(0, ETA_MAX);
              p = $urandom_range(0, PHI_FULL - 1);
            end
            push_req(KIND_SEED, 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, ET_MAX)
                                                 : $urandom_range(0, 1500), e, p);
            if (gen_seeds < SEEDS)
              counted++;
            gen_seeds++;
          end
        end
      end
    end
  endtask

  int k;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed event at the reset settings. The first seed carries a stray
    // new_event, sits in the far corner and wraps across phi zero onto two
    // objects, one of them full scale, so its sum clips. The second seed takes only the
    // zero-Et object. The third reaches an object exactly half a turn away
    // in phi. Seventeen seeds in all, so the last one exceeds the seed
    // budget, and a fresh event then restarts the seed count.
    push_req(KIND_OBJECT, 1'b1, ET_MAX, ETA_MAX, PHI_FULL - 1);
    push_req(KIND_OBJECT, 1'b0, 0, 0, 0);
    push_req(KIND_OBJECT, 1'b0, 5000, ETA_MAX, 0);
    push_req(KIND_OBJECT, 1'b0, 100, 1000, PHI_HALF);
    push_req(KIND_OBJECT, 1'b0, ET_MAX, 1024, PHI_HALF - 1);
    push_req(KIND_SEED, 1'b1, ET_MAX, ETA_MAX, PHI_FULL - 1);
    push_req(KIND_SEED, 1'b0, 0, 0, 0);
    push_req(KIND_SEED, 1'b0, 1, 1000, 0);
    for (k = 4; k <= SEEDS + 1; k++)
      push_req(KIND_SEED, k[0], (k * 587) & ET_MAX, (k * 131) & ETA_MAX,
               (k * 23) & (PHI_FULL - 1));
    push_req(KIND_OBJECT, 1'b1, 1234, 700, 40);
    push_req(KIND_SEED, 1'b0, 4321, 702, 38);
    drain();

    // Exact-position merges only, with a full walk allowed; the register
    // data carries junk above the register widths. The first event here
    // overfills the table, so every seed walks all of it.
    set_cuts('0, 40'hAB_CDEF_0001, 40'h00_1234_0001, 40'h5A_5A5A_5D00);
    gen_events(85, 1'b1);
    drain();

    // Nothing may merge: zero walk limit with the widest cut.
    set_cuts('1, CFG_DATA_W'(16'hFFFF), CFG_DATA_W'(16'hFFFF), '0);
    gen_events(85, 1'b0);
    drain();

    // Moderate random cone and a short walk limit.
    set_cuts(CFG_DATA_W'($urandom_range(0, 1 << 20)),
             CFG_DATA_W'($urandom_range(0, 15)),
             CFG_DATA_W'($urandom_range(0, 15)),
             CFG_DATA_W'($urandom_range(1, 8)));
    gen_events(85, 1'b0);
    drain();

    // Everything merges: the largest weighted distance is far below the
    // widest cut, so Et sums clip often.
    set_cuts('1, CFG_DATA_W'(16'hFFFF), CFG_DATA_W'(16'hFFFF), CFG_DATA_W'(9'd256));
    gen_events(85, 1'b0);
    drain();

    // Eta ignored entirely; only the phi distance decides.
    set_cuts(CFG_DATA_W'($urandom_range(0, 200000)), 40'hFF_FF00_0000,
             CFG_DATA_W'($urandom_range(1, 100)), CFG_DATA_W'(RST_MAX_CONSIDERED));
    gen_events(85, 1'b0);
    drain();

    // Back to the reset settings, with mostly random events.
    set_cuts(CFG_DATA_W'(RST_R2_CUT), CFG_DATA_W'(RST_ETA_WEIGHT),
             CFG_DATA_W'(RST_PHI_WEIGHT), CFG_DATA_W'(RST_MAX_CONSIDERED));
    gen_events(85, 1'b0);
    drain();

    if (errors == 0 && jet_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== seeded_cone_jet_builder.f =====
design/cjb_pkg.sv
design/cjb_ram.sv
design/cjb_dist.sv
design/seeded_cone_jet_builder.sv
tb/tb.sv
